FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the deframe checker RTL.
// Empty bodies when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication or plain property, checked on every rising edge outside reset.
`define DFC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("deframe checker assertion failed");
// Condition that must never hold outside reset.
`define DFC_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("deframe checker forbidden condition seen");
`else
`define DFC_ASSERT(label, clk, rst, prop)
`define DFC_NEVER(label, clk, rst, cond)
`endif

`endif

FILE: rtl/core/dfc_pkg.sv
// Shared types and constants for the datagram deframe checker.
// No dependencies; imported by every module of the block.
package dfc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'h20;
  localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'h30;
  // Start, type, sequence, length, checksum, end.
  localparam logic [POS_W-1:0] FRAME_OVERHEAD = 10'd6;
  localparam logic [POS_W-1:0] POS_MAX        = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] POS_START      = 10'd0;
  localparam logic [POS_W-1:0] POS_TYPE       = 10'd1;
  localparam logic [POS_W-1:0] POS_SEQ        = 10'd2;
  localparam logic [POS_W-1:0] POS_LEN        = 10'd3;
  localparam logic [POS_W-1:0] POS_PAYLOAD    = 10'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MARKER   = 3'd2,
    ST_CHECKSUM = 3'd3,
    ST_LENGTH   = 3'd4
  } status_t;

  typedef struct packed {
    logic              last_byte;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sequence_number;
    logic [BYTE_W-1:0] payload_type;
    status_t           status;
    logic              frame_done;
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    wdata;
  } cfg_write_t;

  // Handshake between input stage and result stage.
  typedef struct packed {
    logic valid;    // input register holds an item
    logic advance;  // item moves into the result register this cycle
  } stage_ctrl_t;

endpackage

FILE: rtl/core/dfc_in_stage.sv
// Input register of the deframe checker: holds one accepted byte request.
// Depends on dfc_pkg.
module dfc_in_stage
  import dfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [BYTE_W-1:0] s_tdata,
  input  logic              s_tlast,
  input  logic              advance,
  output logic              valid,
  output in_item_t          item
);

  // Free when empty or when the held byte leaves this cycle.
  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.data_byte <= s_tdata;
      item.last_byte <= s_tlast;
    end
  end

endmodule

FILE: rtl/core/dfc_frame_check.sv
// Frame state, marker registers and per-byte check logic.
// Depends on dfc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dfc_frame_check
  import dfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_write_t  cfg,
  input  stage_ctrl_t ctrl,
  input  in_item_t    item,
  output result_t     result
);

  logic [BYTE_W-1:0] start_marker;
  logic [BYTE_W-1:0] end_marker;

  logic [POS_W-1:0]  byte_position;
  logic [BYTE_W-1:0] lagged_sum;
  logic [BYTE_W-1:0] previous_byte;
  logic [BYTE_W-1:0] second_previous_byte;
  logic [BYTE_W-1:0] first_byte_seen;
  logic [BYTE_W-1:0] type_seen;
  logic [BYTE_W-1:0] sequence_seen;
  logic [BYTE_W-1:0] declared_length;

  logic [BYTE_W-1:0] sum_before;
  logic [BYTE_W-1:0] first_byte;
  logic [POS_W:0]    payload_end;
  logic              in_payload;
  logic [POS_W-1:0]  len_minus_overhead;
  status_t           status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RESET;
      end_marker   <= END_MARKER_RESET;
    end else if (cfg.we) begin
      unique case (cfg.index)
        CFG_START_MARKER: start_marker <= cfg.wdata;
        CFG_END_MARKER:   end_marker   <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // Second previous byte is still zero for the first two bytes of a frame.
  assign sum_before  = lagged_sum + second_previous_byte;
  assign first_byte  = (byte_position == POS_START) ? item.data_byte : first_byte_seen;
  assign payload_end = {1'b0, POS_PAYLOAD} + {{(POS_W + 1 - BYTE_W){1'b0}}, declared_length};
  assign in_payload  = (byte_position >= POS_PAYLOAD) && ({1'b0, byte_position} < payload_end);
  // pos + 1 - 6; only used once the frame is at least six bytes long
  assign len_minus_overhead = byte_position + 10'd1 - FRAME_OVERHEAD;

  always_comb begin
    if (byte_position < FRAME_OVERHEAD - 10'd1) begin
      status_next = ST_SHORT;
    end else if (first_byte != start_marker || item.data_byte != end_marker) begin
      status_next = ST_MARKER;
    end else if (sum_before != previous_byte) begin
      status_next = ST_CHECKSUM;
    end else if (byte_position == POS_MAX ||
                 {{(POS_W - BYTE_W){1'b0}}, declared_length} != len_minus_overhead) begin
      status_next = ST_LENGTH;
    end else begin
      status_next = ST_OK;
    end
  end

  always_comb begin
    result.payload_valid   = in_payload;
    result.payload_byte    = in_payload ? item.data_byte : '0;
    result.frame_done      = item.last_byte;
    result.status          = item.last_byte ? status_next : ST_OK;
    result.payload_type    = (byte_position == POS_TYPE) ? item.data_byte : type_seen;
    result.sequence_number = (byte_position == POS_SEQ) ? item.data_byte : sequence_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= '0;
      lagged_sum           <= '0;
      previous_byte        <= '0;
      second_previous_byte <= '0;
      first_byte_seen      <= '0;
      type_seen            <= '0;
      sequence_seen        <= '0;
      declared_length      <= '0;
    end else if (ctrl.advance) begin
      if (item.last_byte) begin
        byte_position        <= '0;
        lagged_sum           <= '0;
        previous_byte        <= '0;
        second_previous_byte <= '0;
        first_byte_seen      <= '0;
        type_seen            <= '0;
        sequence_seen        <= '0;
        declared_length      <= '0;
      end else begin
        lagged_sum           <= sum_before;
        second_previous_byte <= previous_byte;
        previous_byte        <= item.data_byte;
        if (byte_position != POS_MAX) begin
          byte_position <= byte_position + 10'd1;
        end
        if (byte_position == POS_START) begin
          first_byte_seen <= item.data_byte;
        end
        if (byte_position == POS_TYPE) begin
          type_seen <= item.data_byte;
        end
        if (byte_position == POS_SEQ) begin
          sequence_seen <= item.data_byte;
        end
        if (byte_position == POS_LEN) begin
          declared_length <= item.data_byte;
        end
      end
    end
  end

  `DFC_ASSERT(a_clear_after_last, clk, rst, ctrl.advance && item.last_byte |=> byte_position == '0 && lagged_sum == '0)
  `DFC_NEVER(a_payload_in_header, clk, rst, result.payload_valid && byte_position < POS_PAYLOAD)
  `DFC_ASSERT(a_pos_holds_when_stalled, clk, rst, !ctrl.advance |=> $stable(byte_position))
  `DFC_NEVER(a_status_without_done, clk, rst, ctrl.valid && result.status != ST_OK && !result.frame_done)

endmodule

FILE: rtl/core/dfc_out_stage.sv
// Result register of the deframe checker with its output handshake.
// Depends on dfc_pkg.
module dfc_out_stage
  import dfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t result,
  output logic    advance,
  output logic    m_tvalid,
  input  logic    m_tready,
  output result_t held
);

  // Load a new result whenever the register is empty or being drained.
  assign advance = in_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held <= result;
    end
  end

endmodule

FILE: rtl/core/datagram_deframe_checker_top.sv
// Top level of the datagram deframe checker: byte stream in, checked byte stream out.
// Depends on dfc_pkg, dfc_in_stage, dfc_frame_check and dfc_out_stage.
//
// Datagram deframe checker. Bytes of a frame (start marker, type, sequence,
// length, payload, checksum, end marker) arrive one request per cycle with
// s_tlast on the final byte; every input request yields exactly one output
// request. Bytes at the declared payload positions come out with m_tuser set;
// on the final byte m_tlast is set and status reports 0 ok, 1 too short,
// 2 bad marker, 3 checksum (8-bit sum of all bytes before the last two),
// 4 length mismatch, first failing check winning. Drop the payload on any
// nonzero status. Throughput is one byte per cycle while the sender offers
// data and the receiver is ready. Output valid rises when the result
// register loads, after the input register has loaded at acceptance; a
// stalled output can hold the result register off. The rate is set by the
// running sum and byte counter, which update once per byte.
// Marker registers are written through cfg_we/cfg_index/cfg_wdata (index 0
// start marker, index 1 end marker, other indexes ignored) and should only be
// changed while no frame is in flight.
module datagram_deframe_checker_top
  import dfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  // byte stream in
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,  // [7:0] data_byte
  input  logic                 s_tlast,  // last_byte
  // checked stream out
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,  // [7:0] payload_byte, [10:8] status,
                                         // [18:11] payload_type,
                                         // [26:19] sequence_number, rest zero
  output logic                 m_tuser,  // payload_valid
  output logic                 m_tlast   // frame_done
);

  cfg_write_t  cfg;
  stage_ctrl_t ctrl;
  in_item_t    item;
  result_t     result;
  result_t     held;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  dfc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .advance  (ctrl.advance),
    .valid    (ctrl.valid),
    .item     (item)
  );

  // Frame state moves forward only when the held byte enters the result register.
  dfc_frame_check u_frame_check (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .ctrl   (ctrl),
    .item   (item),
    .result (result)
  );

  dfc_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ctrl.valid),
    .result   (result),
    .advance  (ctrl.advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .held     (held)
  );

  assign m_tdata = {5'd0, held.sequence_number, held.payload_type, held.status,
                    held.payload_byte};
  assign m_tuser = held.payload_valid;
  assign m_tlast = held.frame_done;

endmodule
